// ===== src/srss_pkg.sv =====
// Package for the sorted record substring search block.
// Holds field widths, command codes and the controller/datapath interface types.
// No dependencies.
package srss_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int NAME_LEN_DEF    = 30;
  localparam int PHONE_LEN_DEF   = 20;
  localparam int MEMO_LEN_DEF    = 40;

  localparam int CMD_W  = 2;
  localparam int SLOT_W = 6;
  localparam int FSEL_W = 2;
  localparam int POS_W  = 6;
  localparam int CHAR_W = 8;
  localparam int RANK_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_REC = 2'd0,
    CMD_WR_PAT = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam logic [FSEL_W-1:0] FSEL_NAME  = 2'd0;
  localparam logic [FSEL_W-1:0] FSEL_PHONE = 2'd1;
  localparam logic [FSEL_W-1:0] FSEL_MEMO  = 2'd2;

  typedef enum logic [1:0] {
    RD_COUNT,
    RD_PLEN,
    RD_CMP,
    RD_MATCH
  } rd_mode_t;

  typedef struct packed {
    logic     wr;
    logic     clr_step;
    logic     srch_init;
    logic     cnt_inc;
    logic     plen_inc;
    logic     round_init;
    logic     cand_inc;
    logic     best_take;
    logic     ci_clr;
    logic     ci_inc;
    logic     pick;
    logic     fld_next;
    logic     k_inc;
    logic     s0_next;
    logic     hit;
    logic     round_inc;
    logic     push_final;
    rd_mode_t rd_mode;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cnt_full;
    logic cnt_zero;
    logic name_zero;
    logic plen_full;
    logic plen_zero;
    logic pat_zero;
    logic cand_end;
    logic cand_done;
    logic best_ok;
    logic cmp_ne;
    logic cmp_lt;
    logic cmp_end;
    logic pos_out;
    logic mf_eq;
    logic mf_zero;
    logic k_last;
    logic fld_last;
    logic hits_zero;
    logic last_round;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== src/srss_dp.sv =====
// Datapath: name, phone, memo and pattern memories, walk counters and result register.
// Driven by srss_ctrl through ctl_cmd_t; reports through ctl_sts_t. Uses srss_pkg.
module srss_dp import srss_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int NAME_LEN    = NAME_LEN_DEF,
  parameter int PHONE_LEN   = PHONE_LEN_DEF,
  parameter int MEMO_LEN    = MEMO_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [SLOT_W-1:0] slot,
  input  logic [FSEL_W-1:0] field_sel,
  input  logic [POS_W-1:0]  position,
  input  logic [CHAR_W-1:0] char_value,
  input  ctl_cmd_t          ctl,
  output ctl_sts_t          sts,
  input  logic              res_ready,
  output logic              res_valid,
  output logic [SLOT_W-1:0] match_slot,
  output logic [RANK_W-1:0] rank,
  output logic              found,
  output logic [RANK_W-1:0] match_total,
  output logic              last
);

  localparam int NAME_D  = MAX_RECORDS * NAME_LEN;
  localparam int PHONE_D = MAX_RECORDS * PHONE_LEN;
  localparam int MEMO_D  = MAX_RECORDS * MEMO_LEN;
  localparam int PAT_D   = MEMO_LEN;
  localparam int NA_W = (NAME_D > 1) ? $clog2(NAME_D) : 1;
  localparam int PH_W = (PHONE_D > 1) ? $clog2(PHONE_D) : 1;
  localparam int ME_W = (MEMO_D > 1) ? $clog2(MEMO_D) : 1;
  localparam int PA_W = (PAT_D > 1) ? $clog2(PAT_D) : 1;
  localparam int SI_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CLR_D0 = (NAME_D > PHONE_D) ? NAME_D : PHONE_D;
  localparam int CLR_D1 = (CLR_D0 > MEMO_D) ? CLR_D0 : MEMO_D;
  localparam int CLR_D  = (CLR_D1 > PAT_D) ? CLR_D1 : PAT_D;
  localparam int CLR_W  = (CLR_D > 1) ? $clog2(CLR_D) : 1;

  logic [CHAR_W-1:0] name_mem  [NAME_D];
  logic [CHAR_W-1:0] phone_mem [PHONE_D];
  logic [CHAR_W-1:0] memo_mem  [MEMO_D];
  logic [CHAR_W-1:0] pat_mem   [PAT_D];

  logic [CLR_W-1:0]  clr_addr;
  logic [RANK_W-1:0] cnt;
  logic [RANK_W-1:0] plen;
  logic [RANK_W-1:0] round;
  logic [RANK_W-1:0] cand;
  logic [SLOT_W-1:0] best;
  logic              best_ok;
  logic [MAX_RECORDS-1:0] emitted;
  logic [POS_W-1:0]  ci;
  logic [FSEL_W-1:0] fld;
  logic [POS_W-1:0]  s0;
  logic [POS_W-1:0]  k;
  logic [RANK_W-1:0] hits;
  logic [SLOT_W-1:0] pend;

  logic [CHAR_W-1:0] name_a, name_b, phone_q, memo_q, pat_q;
  logic [RANK_W-1:0] pos_sum;

  logic              name_we, phone_we, memo_we, pat_we;
  logic [NA_W-1:0]   name_wa, name_ra_a, name_ra_b;
  logic [PH_W-1:0]   phone_wa, phone_ra;
  logic [ME_W-1:0]   memo_wa, memo_ra;
  logic [PA_W-1:0]   pat_wa, pat_ra;
  logic [CHAR_W-1:0] wd;
  logic              rec_ok;
  logic [CHAR_W-1:0] mf;
  int                cap;

  assign pos_sum = {1'b0, s0} + {1'b0, k};
  assign rec_ok  = ctl.wr && (cmd_t'(cmd) == CMD_WR_REC) && (int'(slot) < MAX_RECORDS);

  always_comb begin
    wd       = ctl.clr_step ? '0 : char_value;
    name_wa  = NA_W'(int'(slot) * NAME_LEN + int'(position));
    phone_wa = PH_W'(int'(slot) * PHONE_LEN + int'(position));
    memo_wa  = ME_W'(int'(slot) * MEMO_LEN + int'(position));
    pat_wa   = PA_W'(position);
    name_we  = rec_ok && field_sel == FSEL_NAME && int'(position) < NAME_LEN;
    phone_we = rec_ok && field_sel == FSEL_PHONE && int'(position) < PHONE_LEN;
    memo_we  = rec_ok && field_sel == FSEL_MEMO && int'(position) < MEMO_LEN;
    pat_we   = ctl.wr && (cmd_t'(cmd) == CMD_WR_PAT) && int'(position) < PAT_D;
    if (ctl.clr_step) begin
      name_wa  = NA_W'(clr_addr);
      phone_wa = PH_W'(clr_addr);
      memo_wa  = ME_W'(clr_addr);
      pat_wa   = PA_W'(clr_addr);
      name_we  = int'(clr_addr) < NAME_D;
      phone_we = int'(clr_addr) < PHONE_D;
      memo_we  = int'(clr_addr) < MEMO_D;
      pat_we   = int'(clr_addr) < PAT_D;
    end
  end

  always_comb begin
    case (ctl.rd_mode)
      RD_COUNT: name_ra_a = NA_W'(int'(cnt[SI_W-1:0]) * NAME_LEN);
      RD_CMP:   name_ra_a = NA_W'(int'(cand[SI_W-1:0]) * NAME_LEN + int'(ci));
      default:  name_ra_a = NA_W'(int'(best) * NAME_LEN + int'(pos_sum));
    endcase
    name_ra_b = NA_W'(int'(best) * NAME_LEN + int'(ci));
    phone_ra  = PH_W'(int'(best) * PHONE_LEN + int'(pos_sum));
    memo_ra   = ME_W'(int'(best) * MEMO_LEN + int'(pos_sum));
    pat_ra    = (ctl.rd_mode == RD_PLEN) ? PA_W'(plen) : PA_W'(k);
  end

  always_ff @(posedge clk) begin
    if (name_we) begin
      name_mem[name_wa] <= wd;
    end
    name_a <= name_mem[name_ra_a];
    name_b <= name_mem[name_ra_b];
  end

  always_ff @(posedge clk) begin
    if (phone_we) begin
      phone_mem[phone_wa] <= wd;
    end
    phone_q <= phone_mem[phone_ra];
  end

  always_ff @(posedge clk) begin
    if (memo_we) begin
      memo_mem[memo_wa] <= wd;
    end
    memo_q <= memo_mem[memo_ra];
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_wa] <= wd;
    end
    pat_q <= pat_mem[pat_ra];
  end

  always_comb begin
    case (fld)
      FSEL_NAME: begin
        mf  = name_a;
        cap = NAME_LEN;
      end
      FSEL_PHONE: begin
        mf  = phone_q;
        cap = PHONE_LEN;
      end
      default: begin
        mf  = memo_q;
        cap = MEMO_LEN;
      end
    endcase
  end

  always_comb begin
    sts.clr_last   = int'(clr_addr) == CLR_D - 1;
    sts.cnt_full   = int'(cnt) == MAX_RECORDS;
    sts.cnt_zero   = cnt == '0;
    sts.name_zero  = name_a == '0;
    sts.plen_full  = int'(plen) == PAT_D;
    sts.plen_zero  = plen == '0;
    sts.pat_zero   = pat_q == '0;
    sts.cand_end   = cand == cnt;
    sts.cand_done  = emitted[cand[SI_W-1:0]];
    sts.best_ok    = best_ok;
    sts.cmp_ne     = name_a != name_b;
    sts.cmp_lt     = name_a < name_b;
    sts.cmp_end    = (name_a == '0) || (int'(ci) == NAME_LEN - 1);
    sts.pos_out    = int'(pos_sum) >= cap;
    sts.mf_eq      = mf == pat_q;
    sts.mf_zero    = mf == '0;
    sts.k_last     = ({1'b0, k} + RANK_W'(1)) == plen;
    sts.fld_last   = fld == FSEL_MEMO;
    sts.hits_zero  = hits == '0;
    sts.last_round = (round + RANK_W'(1)) == cnt;
    sts.out_free   = !res_valid || res_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_step) begin
      clr_addr <= (int'(clr_addr) == CLR_D - 1) ? '0 : clr_addr + CLR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.srch_init) begin
      cnt     <= '0;
      plen    <= '0;
      round   <= '0;
      hits    <= '0;
      emitted <= '0;
    end
    if (ctl.cnt_inc) cnt <= cnt + RANK_W'(1);
    if (ctl.plen_inc) plen <= plen + RANK_W'(1);
    if (ctl.round_inc) round <= round + RANK_W'(1);
    if (ctl.round_init) begin
      cand    <= '0;
      best_ok <= 1'b0;
    end
    if (ctl.cand_inc) cand <= cand + RANK_W'(1);
    if (ctl.best_take) begin
      best    <= SLOT_W'(cand);
      best_ok <= 1'b1;
    end
    if (ctl.ci_clr) ci <= '0;
    if (ctl.ci_inc) ci <= ci + POS_W'(1);
    if (ctl.pick) begin
      emitted[best[SI_W-1:0]] <= 1'b1;
      fld <= FSEL_NAME;
      s0  <= '0;
      k   <= '0;
    end
    if (ctl.fld_next) begin
      fld <= fld + FSEL_W'(1);
      s0  <= '0;
      k   <= '0;
    end
    if (ctl.k_inc) k <= k + POS_W'(1);
    if (ctl.s0_next) begin
      s0 <= s0 + POS_W'(1);
      k  <= '0;
    end
    if (ctl.hit) begin
      pend <= best;
      hits <= hits + RANK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((ctl.hit && hits != '0) || ctl.push_final) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hit && hits != '0) begin
      match_slot  <= pend;
      rank        <= hits;
      found       <= 1'b1;
      match_total <= '0;
      last        <= 1'b0;
    end else if (ctl.push_final) begin
      match_slot  <= sts.hits_zero ? '0 : pend;
      rank        <= hits;
      found       <= !sts.hits_zero;
      match_total <= hits;
      last        <= 1'b1;
    end
  end

endmodule

// ===== src/srss_ctrl.sv =====
// Controller for the sorted record substring search block: clear sweep, record count,
// selection of records in name order and pattern match walk. Uses srss_pkg.
module srss_ctrl import srss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [CMD_W-1:0] cmd,
  output logic             req_ready,
  input  ctl_sts_t         sts,
  output ctl_cmd_t         ctl
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_COUNT_RD, S_COUNT_CHK, S_PLEN_RD, S_PLEN_CHK, S_ROUND,
    S_SCAN, S_CMP_RD, S_CMP_CHK, S_PICK, S_MATCH_RD, S_MATCH_CHK, S_HIT,
    S_ROUND_NEXT, S_FINAL
  } state_t;

  state_t state, state_next;

  assign req_ready = state == S_IDLE;

  always_comb begin
    ctl        = '0;
    ctl.rd_mode = RD_MATCH;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (cmd_t'(cmd))
            CMD_SEARCH: begin
              ctl.srch_init = 1'b1;
              state_next = S_COUNT_RD;
            end
            CMD_CLEAR: state_next = S_CLEAR;
            default:   ctl.wr = 1'b1;
          endcase
        end
      end
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_COUNT_RD: begin
        ctl.rd_mode = RD_COUNT;
        state_next = sts.cnt_full ? S_PLEN_RD : S_COUNT_CHK;
      end
      S_COUNT_CHK: begin
        if (sts.name_zero) begin
          state_next = S_PLEN_RD;
        end else begin
          ctl.cnt_inc = 1'b1;
          state_next = S_COUNT_RD;
        end
      end
      S_PLEN_RD: begin
        ctl.rd_mode = RD_PLEN;
        state_next = sts.plen_full ? S_ROUND : S_PLEN_CHK;
      end
      S_PLEN_CHK: begin
        if (sts.pat_zero) begin
          state_next = S_ROUND;
        end else begin
          ctl.plen_inc = 1'b1;
          state_next = S_PLEN_RD;
        end
      end
      S_ROUND: begin
        if (sts.plen_zero || sts.cnt_zero) begin
          state_next = S_FINAL;
        end else begin
          ctl.round_init = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.cand_end) begin
          state_next = S_PICK;
        end else if (sts.cand_done) begin
          ctl.cand_inc = 1'b1;
        end else if (!sts.best_ok) begin
          ctl.best_take = 1'b1;
          ctl.cand_inc = 1'b1;
        end else begin
          ctl.ci_clr = 1'b1;
          state_next = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        ctl.rd_mode = RD_CMP;
        state_next = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (sts.cmp_ne) begin
          ctl.best_take = sts.cmp_lt;
          ctl.cand_inc = 1'b1;
          state_next = S_SCAN;
        end else if (sts.cmp_end) begin
          ctl.cand_inc = 1'b1;
          state_next = S_SCAN;
        end else begin
          ctl.ci_inc = 1'b1;
          state_next = S_CMP_RD;
        end
      end
      S_PICK: begin
        ctl.pick = 1'b1;
        state_next = S_MATCH_RD;
      end
      S_MATCH_RD: begin
        if (sts.pos_out) begin
          if (sts.fld_last) state_next = S_ROUND_NEXT;
          else ctl.fld_next = 1'b1;
        end else begin
          state_next = S_MATCH_CHK;
        end
      end
      S_MATCH_CHK: begin
        state_next = S_MATCH_RD;
        if (sts.mf_eq) begin
          if (sts.k_last) state_next = S_HIT;
          else ctl.k_inc = 1'b1;
        end else if (sts.mf_zero) begin
          if (sts.fld_last) state_next = S_ROUND_NEXT;
          else ctl.fld_next = 1'b1;
        end else begin
          ctl.s0_next = 1'b1;
        end
      end
      S_HIT: begin
        if (sts.hits_zero || sts.out_free) begin
          ctl.hit = 1'b1;
          state_next = S_ROUND_NEXT;
        end
      end
      S_ROUND_NEXT: begin
        ctl.round_inc = 1'b1;
        state_next = sts.last_round ? S_FINAL : S_ROUND;
      end
      S_FINAL: begin
        if (sts.out_free) begin
          ctl.push_final = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/sorted_record_substring_search_top.sv =====
// Top level: sorted record substring search. A search first sizes up the record count and
// the pattern length, then runs count rounds, each a character-by-character name compare
// walk over the unsent records and a naive match walk; results leave through a one-entry
// output register. Reset, and every clear request, run a zeroing sweep over the deepest
// store, during which no request is taken. Depends on srss_pkg, srss_ctrl, srss_dp.
module sorted_record_substring_search_top import srss_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF,
  parameter int NAME_LEN    = NAME_LEN_DEF,
  parameter int PHONE_LEN   = PHONE_LEN_DEF,
  parameter int MEMO_LEN    = MEMO_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [SLOT_W-1:0] slot,
  input  logic [FSEL_W-1:0] field_sel,
  input  logic [POS_W-1:0]  position,
  input  logic [CHAR_W-1:0] char_value,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [SLOT_W-1:0] match_slot,
  output logic [RANK_W-1:0] rank,
  output logic              found,
  output logic [RANK_W-1:0] match_total,
  output logic              last
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  srss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .cmd       (cmd),
    .req_ready (req_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  srss_dp #(
    .MAX_RECORDS (MAX_RECORDS),
    .NAME_LEN    (NAME_LEN),
    .PHONE_LEN   (PHONE_LEN),
    .MEMO_LEN    (MEMO_LEN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .slot        (slot),
    .field_sel   (field_sel),
    .position    (position),
    .char_value  (char_value),
    .ctl         (ctl),
    .sts         (sts),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .match_slot  (match_slot),
    .rank        (rank),
    .found       (found),
    .match_total (match_total),
    .last        (last)
  );

endmodule

// ===== src/srss_chk.sv =====
// Port checker for sorted_record_substring_search_top, attached by bind.
// Uses srss_pkg for widths.
module srss_chk import srss_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [SLOT_W-1:0] match_slot,
  input logic [RANK_W-1:0] rank,
  input logic              found,
  input logic [RANK_W-1:0] match_total,
  input logic              last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(rank) && $stable(last))
    else $error("result changed while stalled");

  a_none: assert property (@(posedge clk) disable iff (rst)
    res_valid && !found |-> last && rank == '0 && match_total == '0 && match_slot == '0)
    else $error("no-match result malformed");

  a_mid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> found && match_total == '0 && rank != '0)
    else $error("intermediate result malformed");

  a_total: assert property (@(posedge clk) disable iff (rst)
    res_valid && last && found |-> match_total == rank)
    else $error("total does not equal final rank");

endmodule

bind sorted_record_substring_search_top srss_chk u_chk (.*);
